// ----- sv/greedy_note_dispenser_assert.svh -----
// Assertion macros for the checker file of the note dispenser.
`ifndef GREEDY_NOTE_DISPENSER_ASSERT_SVH
`define GREEDY_NOTE_DISPENSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GND_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GND_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/gnd_pkg.sv -----
package gnd_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AMT_W      = 24;
    localparam int VAL_W      = 16;
    localparam int CNT_W      = 16;
    localparam int STAT_W     = 2;
    localparam int DIV_STEP_W = $clog2(AMT_W + 1);

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic {
        CMD_LOAD     = 1'b0,
        CMD_WITHDRAW = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_NOPAY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic              command;
        logic [AMT_W-1:0]  amount;
        logic [VAL_W-1:0]  note_value;
        logic [CNT_W-1:0]  note_count;
    } t_in_word;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  paid_value;
        logic [CNT_W-1:0]  notes_taken;
        logic              last;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_SCAN,
        S_LD_DONE,
        S_RESULT,
        S_WD_SCAN,
        S_WD_DIVGO,
        S_WD_DIV,
        S_WD_MUL,
        S_WD_SUB,
        S_WD_PAY
    } t_state;

    typedef struct packed {
        logic             start;
        logic [AMT_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [AMT_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- sv/gnd_div.sv -----
module gnd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gnd_pkg::t_div_req i_req,
    output gnd_pkg::t_div_rsp o_rsp
);
    import gnd_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [VAL_W-1:0]      r_part;
    logic [AMT_W-1:0]      r_quo;
    logic [VAL_W-1:0]      r_dvs;

    logic [VAL_W:0] w_trial;
    logic [VAL_W:0] w_diff;
    logic           w_ge;

    // One quotient bit per cycle: the dividend shifts out of r_quo into the
    // partial remainder while the quotient bits shift in behind it.
    assign w_trial = {r_part, r_quo[AMT_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + DIV_STEP_W'(1);
                if (r_step == DIV_STEP_W'(AMT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_part <= '0;
            r_quo  <= i_req.dividend;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_part <= w_ge ? w_diff[VAL_W-1:0] : w_trial[VAL_W-1:0];
            r_quo  <= {r_quo[AMT_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- sv/greedy_note_dispenser.sv -----
// Note dispenser with a table of SLOTS denominations and their note counts.
// A load word scans every slot and gives one result word; a load with a
// zero note value or a zero-amount withdraw skips the scan and goes
// straight to its result word. A withdraw word finds denominations in
// falling order; each one costs a scan of all slots (one slot per cycle),
// a start of the shared restoring divider (one quotient bit per cycle),
// then a cap, a multiply and a subtract. The whole search runs twice,
// once to prove that the amount can be paid and once to emit result
// words and update the counts, with a pay step for each result word.
// An output stall holds the block in its result or pay state.
// The block takes no new word until the current one is finished, but its
// output register lets it accept the next word while the last result waits.
module greedy_note_dispenser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gnd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gnd_pkg::t_out_word o_out_word
);
    import gnd_pkg::*;

    localparam logic [VAL_W:0] PREV_INIT = {1'b1, {VAL_W{1'b0}}};

    t_state r_state, n_state;

    // Denomination table.
    logic             r_used  [SLOTS];
    logic [VAL_W-1:0] r_value [SLOTS];
    logic [CNT_W-1:0] r_count [SLOTS];

    t_in_word         r_in;
    logic [SLOT_W-1:0] r_idx;
    logic [AMT_W-1:0] r_rem;
    logic [VAL_W:0]   r_prev;
    logic             r_pay;
    logic [STAT_W-1:0] r_status;

    logic              r_found;
    logic [SLOT_W-1:0] r_best_idx;
    logic [VAL_W-1:0]  r_best_val;
    logic [CNT_W-1:0]  r_best_cnt;
    logic [CNT_W-1:0]  r_take;
    logic [CNT_W+VAL_W-1:0] r_prod;

    logic              r_mfound;
    logic [SLOT_W-1:0] r_midx;
    logic [CNT_W-1:0]  r_mcnt;
    logic              r_ffound;
    logic [SLOT_W-1:0] r_fidx;

    logic      r_out_valid;
    t_out_word r_out;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic             w_used;
    logic [VAL_W-1:0] w_val;
    logic [CNT_W-1:0] w_cnt;
    logic             w_last_idx;
    logic             w_cand;
    logic             w_out_free;
    logic             w_accept;
    logic [AMT_W-1:0] w_rem_sub;
    logic [CNT_W-1:0] w_cap;
    logic [CNT_W:0]   w_sum;
    logic [CNT_W-1:0] w_pay_left;

    // Decoded controls.
    logic              c_wr_en;
    logic [SLOT_W-1:0] c_wr_idx;
    logic              c_wr_used;
    logic [VAL_W-1:0]  c_wr_val;
    logic [CNT_W-1:0]  c_wr_cnt;
    logic              c_out_load;
    t_out_word         c_out_word;

    gnd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign w_used     = r_used[r_idx];
    assign w_val      = r_value[r_idx];
    assign w_cnt      = r_count[r_idx];
    assign w_last_idx = (r_idx == SLOT_W'(SLOTS - 1));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_rem_sub  = r_rem - r_prod[AMT_W-1:0];
    assign w_sum      = {1'b0, r_mcnt} + {1'b0, r_in.note_count};
    assign w_pay_left = r_best_cnt - r_take;

    // Values in the table are unique, so the next denomination is the
    // largest one below the previous pick that still fits the remainder.
    assign w_cand = w_used && (w_cnt != '0)
                 && ({{(AMT_W-VAL_W){1'b0}}, w_val} <= r_rem)
                 && ({1'b0, w_val} < r_prev)
                 && (!r_found || (w_val > r_best_val));

    assign w_cap = (div_rsp.quotient > {{(AMT_W-CNT_W){1'b0}}, r_best_cnt})
                 ? r_best_cnt : div_rsp.quotient[CNT_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_word.command == CMD_LOAD) begin
                        n_state = (i_in_word.note_value == '0) ? S_RESULT : S_LD_SCAN;
                    end else begin
                        n_state = (i_in_word.amount == '0) ? S_RESULT : S_WD_SCAN;
                    end
                end
            end
            S_LD_SCAN: begin
                if (w_last_idx) begin
                    n_state = S_LD_DONE;
                end
            end
            S_LD_DONE: n_state = S_RESULT;
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_WD_SCAN: begin
                if (w_last_idx) begin
                    n_state = (r_found || w_cand) ? S_WD_DIVGO : S_RESULT;
                end
            end
            S_WD_DIVGO: n_state = S_WD_DIV;
            S_WD_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_WD_MUL;
                end
            end
            S_WD_MUL: n_state = S_WD_SUB;
            S_WD_SUB: n_state = r_pay ? S_WD_PAY : S_WD_SCAN;
            S_WD_PAY: begin
                if (w_out_free) begin
                    n_state = (r_rem == '0) ? S_IDLE : S_WD_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_rem;
        div_req.divisor  = r_best_val;
        c_wr_en          = 1'b0;
        c_wr_idx         = r_best_idx;
        c_wr_used        = 1'b0;
        c_wr_val         = '0;
        c_wr_cnt         = '0;
        c_out_load       = 1'b0;
        c_out_word       = '{status: r_status, paid_value: '0, notes_taken: '0, last: 1'b1};
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_LD_DONE: begin
                if (r_mfound) begin
                    c_wr_en   = 1'b1;
                    c_wr_idx  = r_midx;
                    c_wr_used = 1'b1;
                    c_wr_val  = r_in.note_value;
                    c_wr_cnt  = w_sum[CNT_W] ? COUNT_MAX : w_sum[CNT_W-1:0];
                end else if (r_in.note_count != '0 && r_ffound) begin
                    c_wr_en   = 1'b1;
                    c_wr_idx  = r_fidx;
                    c_wr_used = 1'b1;
                    c_wr_val  = r_in.note_value;
                    c_wr_cnt  = r_in.note_count;
                end
            end
            S_RESULT: c_out_load = w_out_free;
            S_WD_DIVGO: div_req.start = 1'b1;
            S_WD_PAY: begin
                c_out_load = w_out_free;
                c_out_word = '{status: STAT_OK, paid_value: r_best_val,
                               notes_taken: r_take, last: (r_rem == '0)};
                // An emptied slot is freed along with its value.
                c_wr_en   = w_out_free;
                c_wr_used = (w_pay_left != '0);
                c_wr_val  = (w_pay_left != '0) ? r_best_val : '0;
                c_wr_cnt  = w_pay_left;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_used[i]  <= 1'b0;
                r_value[i] <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (c_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (c_wr_en) begin
                r_used[c_wr_idx]  <= c_wr_used;
                r_value[c_wr_idx] <= c_wr_val;
                r_count[c_wr_idx] <= c_wr_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_out_load) begin
            r_out <= c_out_word;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_in     <= i_in_word;
                    r_idx    <= '0;
                    r_found  <= 1'b0;
                    r_mfound <= 1'b0;
                    r_ffound <= 1'b0;
                    r_rem    <= i_in_word.amount;
                    r_prev   <= PREV_INIT;
                    r_pay    <= 1'b0;
                    r_status <= STAT_OK;
                end
            end
            S_LD_SCAN: begin
                r_idx <= r_idx + SLOT_W'(1);
                if (!r_mfound && w_used && (w_val == r_in.note_value)) begin
                    r_mfound <= 1'b1;
                    r_midx   <= r_idx;
                    r_mcnt   <= w_cnt;
                end
                if (!r_ffound && !w_used) begin
                    r_ffound <= 1'b1;
                    r_fidx   <= r_idx;
                end
            end
            S_LD_DONE: begin
                if (!r_mfound && r_in.note_count != '0 && !r_ffound) begin
                    r_status <= STAT_FULL;
                end else begin
                    r_status <= STAT_OK;
                end
            end
            S_WD_SCAN: begin
                r_idx <= r_idx + SLOT_W'(1);
                if (w_cand) begin
                    r_found    <= 1'b1;
                    r_best_idx <= r_idx;
                    r_best_val <= w_val;
                    r_best_cnt <= w_cnt;
                end
                if (w_last_idx && !(r_found || w_cand)) begin
                    r_status <= STAT_NOPAY;
                end
            end
            S_WD_DIV: begin
                if (div_rsp.done) begin
                    r_take <= w_cap;
                end
            end
            S_WD_MUL: r_prod <= (CNT_W+VAL_W)'(r_take) * (CNT_W+VAL_W)'(r_best_val);
            S_WD_SUB: begin
                r_idx   <= '0;
                r_found <= 1'b0;
                if (!r_pay && w_rem_sub == '0) begin
                    // The amount can be paid: run the search again, this time
                    // emitting words and committing the counts.
                    r_rem  <= r_in.amount;
                    r_prev <= PREV_INIT;
                    r_pay  <= 1'b1;
                end else begin
                    r_rem  <= w_rem_sub;
                    r_prev <= {1'b0, r_best_val};
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ----- sv/gnd_chk.sv -----
`include "greedy_note_dispenser_assert.svh"

module gnd_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input gnd_pkg::t_out_word o_out_word
);
    import gnd_pkg::*;

    logic w_stall;
    logic w_fail;
    logic w_empty_ok;
    logic w_in_take;

    assign w_stall    = o_out_valid && !i_out_ready;
    assign w_fail     = o_out_valid && (o_out_word.status != STAT_OK);
    assign w_empty_ok = o_out_valid && (o_out_word.status == STAT_OK)
                     && (o_out_word.paid_value == '0);
    assign w_in_take  = i_in_valid && o_in_ready;

    // A waiting result word holds until it is taken.
    `GND_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall,
                     o_out_valid && $stable(o_out_word))

    // After taking a command the block is not ready in the next cycle.
    `GND_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, w_in_take, !o_in_ready)

    // Failure and table-full words carry no notes and close their command.
    `GND_ASSERT_NOW(a_fail_alone, i_clk, i_rst_n, w_fail,
                    o_out_word.last && o_out_word.paid_value == '0
                    && o_out_word.notes_taken == '0)

    // A word with no denomination is a load or zero-amount reply.
    `GND_ASSERT_NOW(a_empty_last, i_clk, i_rst_n, w_empty_ok,
                    o_out_word.last && o_out_word.notes_taken == '0)

    // A paid denomination always comes with at least one note.
    `GND_ASSERT_NOW(a_paid_nonzero, i_clk, i_rst_n,
                    o_out_valid && o_out_word.paid_value != '0,
                    o_out_word.notes_taken != '0 && o_out_word.status == STAT_OK)

endmodule

bind greedy_note_dispenser gnd_chk u_gnd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// ----- tb/sv/tb_greedy_note_dispenser.sv -----
module tb_greedy_note_dispenser;
    import gnd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_WORDS = 220;
    localparam int SETTLE_WAIT  = 1000;

    // Tracks the note table and holds the result words still owed by the block.
    class dispense_board;
        logic [VAL_W-1:0] val_q  [SLOTS];
        logic [CNT_W-1:0] cnt_q  [SLOTS];
        bit               used_q [SLOTS];
        t_out_word        owed_words [$];
        int               errors;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                val_q[i]  = '0;
                cnt_q[i]  = '0;
                used_q[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function int owed_count();
            return owed_words.size();
        endfunction

        function void owe(logic [STAT_W-1:0] st, logic [VAL_W-1:0] pv,
                          logic [CNT_W-1:0] nt, logic lst);
            t_out_word w;
            w.status      = st;
            w.paid_value  = pv;
            w.notes_taken = nt;
            w.last        = lst;
            owed_words.push_back(w);
        endfunction

        function logic [STAT_W-1:0] load_table(logic [VAL_W-1:0] v, logic [CNT_W-1:0] c);
            int          free_slot;
            int unsigned sum;
            free_slot = -1;
            if (v == '0) return STAT_OK;
            for (int i = 0; i < SLOTS; i++) begin
                if (used_q[i] && val_q[i] == v) begin
                    sum = 32'(cnt_q[i]) + 32'(c);
                    cnt_q[i] = (sum > 32'(COUNT_MAX)) ? COUNT_MAX : sum[CNT_W-1:0];
                    return STAT_OK;
                end
                if (!used_q[i] && free_slot < 0) free_slot = i;
            end
            if (c == '0) return STAT_OK;
            if (free_slot < 0) return STAT_FULL;
            used_q[free_slot] = 1'b1;
            val_q[free_slot]  = v;
            cnt_q[free_slot]  = c;
            return STAT_OK;
        endfunction

        // Greedy payout on a scratch copy of the counts; the table changes
        // only when the whole amount is covered.
        function void pay_out(logic [AMT_W-1:0] amt);
            int unsigned      left  [SLOTS];
            logic [VAL_W-1:0] pay_v [SLOTS];
            int unsigned      pay_n [SLOTS];
            int unsigned      rem;
            int unsigned      q;
            int               n;
            int               best;
            if (amt == '0) begin
                owe(STAT_OK, '0, '0, 1'b1);
                return;
            end
            rem = 32'(amt);
            n   = 0;
            for (int i = 0; i < SLOTS; i++) left[i] = used_q[i] ? 32'(cnt_q[i]) : 0;
            while (rem != 0 && n < SLOTS) begin
                best = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (left[i] != 0 && val_q[i] != '0 && 32'(val_q[i]) <= rem &&
                        (best < 0 || val_q[i] > val_q[best]))
                        best = i;
                end
                if (best < 0) break;
                q = rem / 32'(val_q[best]);
                if (q > left[best]) q = left[best];
                left[best] -= q;
                rem -= q * 32'(val_q[best]);
                pay_v[n] = val_q[best];
                pay_n[n] = q;
                n++;
            end
            if (rem != 0) begin
                owe(STAT_NOPAY, '0, '0, 1'b1);
                return;
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (used_q[i]) begin
                    cnt_q[i] = left[i][CNT_W-1:0];
                    if (left[i] == 0) begin
                        used_q[i] = 1'b0;
                        val_q[i]  = '0;
                    end
                end
            end
            for (int k = 0; k < n; k++)
                owe(STAT_OK, pay_v[k], pay_n[k][CNT_W-1:0], (k == n - 1));
        endfunction

        function void note_input(t_in_word w);
            if (w.command == CMD_LOAD)
                owe(load_table(w.note_value, w.note_count), '0, '0, 1'b1);
            else
                pay_out(w.amount);
        endfunction

        // Builds an amount from notes actually on hand, so most withdrawals
        // get through the whole payout path.
        function logic [AMT_W-1:0] payable_amount();
            longint unsigned sum;
            longint unsigned part;
            int unsigned     k;
            sum = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (used_q[i]) begin
                    case ($urandom_range(0, 3))
                        1:       k = $urandom_range(0, (cnt_q[i] < 6) ? cnt_q[i] : 16'd5);
                        2:       k = 32'(cnt_q[i]);
                        default: k = 0;
                    endcase
                    part = 64'(val_q[i]);
                    part = part * k;
                    if (sum + part <= 64'hFF_FFFF) sum += part;
                end
            end
            if (sum == 0) sum = 64'($urandom_range(1, 300));
            return sum[AMT_W-1:0];
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_result(t_out_word got);
            t_out_word exp_w;
            if (owed_words.size() == 0) begin
                report($sformatf("result word %h arrived with nothing owed", got));
                return;
            end
            exp_w = owed_words.pop_front();
            if (got.status !== exp_w.status)
                report($sformatf("status %0d, wanted %0d", got.status, exp_w.status));
            if (got.paid_value !== exp_w.paid_value)
                report($sformatf("paid_value %0d, wanted %0d",
                                 got.paid_value, exp_w.paid_value));
            if (got.notes_taken !== exp_w.notes_taken)
                report($sformatf("notes_taken %0d, wanted %0d",
                                 got.notes_taken, exp_w.notes_taken));
            if (got.last !== exp_w.last)
                report($sformatf("last %0b, wanted %0b", got.last, exp_w.last));
        endtask
    endclass

    logic      i_clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;
    bit        no_idle;
    int        cycles;

    dispense_board board = new();

    greedy_note_dispenser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) board.note_input(in_word);
            if (out_valid && out_ready) board.check_result(out_word);
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Receiver side: alternating runs of ready and stall.
    initial begin
        int n;
        out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                out_ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task push_word(t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    task load_notes(logic [VAL_W-1:0] v, logic [CNT_W-1:0] c);
        t_in_word w;
        w.command    = CMD_LOAD;
        w.amount     = AMT_W'($urandom);
        w.note_value = v;
        w.note_count = c;
        push_word(w);
    endtask

    task withdraw(logic [AMT_W-1:0] a);
        t_in_word w;
        w.command    = CMD_WITHDRAW;
        w.amount     = a;
        w.note_value = VAL_W'($urandom);
        w.note_count = CNT_W'($urandom);
        push_word(w);
    endtask

    task drain_owed();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (board.owed_count() != 0) @(negedge i_clk);
    endtask

    logic [VAL_W-1:0] pool [10] = '{1, 2, 5, 10, 20, 50, 100, 200, 500, 1000};

    initial begin
        t_in_word w;
        int       r;
        cycles   = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        no_idle  = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Directed part: empty table, ignored loads, a full table, saturation,
        // a payout over every slot and a slot emptied and reused.
        withdraw('0);
        withdraw(24'd5);
        load_notes('0, 16'd10);
        load_notes(16'd7, '0);
        for (int i = 0; i < 8; i++) load_notes(pool[i], 16'd3);
        load_notes(16'hFFFF, 16'd1);
        load_notes(16'd5, '0);
        load_notes(16'd1, 16'hFFFF);
        withdraw(24'd388);
        withdraw(24'hFF_FFFF);
        w = '{command: CMD_WITHDRAW, amount: 24'd3, note_value: '1, note_count: '1};
        push_word(w);
        w = '{command: CMD_LOAD, amount: '1, note_value: 16'd2, note_count: 16'd1};
        push_word(w);
        withdraw(24'd400);
        load_notes(16'hFFFF, 16'hFFFF);
        withdraw(24'd16711425);
        withdraw(24'd6);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) drain_owed();
            no_idle = (n >= 150 && n < 180);
            r = $urandom_range(0, 99);
            if (r < 35) begin
                if ($urandom_range(0, 7) == 0)
                    load_notes(pool[$urandom_range(0, 9)], CNT_W'($urandom));
                else
                    load_notes(pool[$urandom_range(0, 9)], CNT_W'($urandom_range(0, 20)));
            end else if (r < 45) begin
                if ($urandom_range(0, 9) == 0)
                    load_notes('0, CNT_W'($urandom));
                else
                    load_notes(VAL_W'($urandom), ($urandom_range(0, 1) == 1) ?
                               CNT_W'($urandom) : CNT_W'($urandom_range(0, 9)));
            end else if (r < 85) begin
                withdraw(board.payable_amount());
            end else if (r < 93) begin
                withdraw(AMT_W'($urandom_range(0, 2000)));
            end else begin
                withdraw(AMT_W'($urandom));
            end
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        while (board.owed_count() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (board.errors == 0 && board.owed_count() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ----- greedy_note_dispenser.f -----
+incdir+sv
sv/gnd_pkg.sv
sv/gnd_div.sv
sv/greedy_note_dispenser.sv
sv/gnd_chk.sv
tb/sv/tb_greedy_note_dispenser.sv
